FILE: design/mehd_pkg.sv
// constants, sequencer codes and the shimmer sine table for the motion energy haptic driver
// no dependencies; imported by motion_energy_haptic_driver and its testbench
package mehd_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CHARGE_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_PER_MS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MOTION_DEADZONE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INACT_TIMEOUT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SHIMMER_STEP    = 3'd4;
  localparam int unsigned CfgDataW = 20;

  // register reset values
  localparam logic [19:0] ChargeGainRst   = 20'd429497;
  localparam logic [15:0] DecayPerMsRst   = 16'd10066;
  localparam logic [15:0] DeadzoneRst     = 16'd768;
  localparam logic [15:0] InactTimeoutRst = 16'd10000;
  localparam logic [11:0] ShimmerStepRst  = 12'd695;

  // sequencer state codes
  localparam int unsigned StW = 3;
  localparam logic [StW-1:0] S_IDLE = 3'd0;
  localparam logic [StW-1:0] S_GM   = 3'd1;
  localparam logic [StW-1:0] S_HI   = 3'd2;
  localparam logic [StW-1:0] S_LO   = 3'd3;
  localparam logic [StW-1:0] S_DEC  = 3'd4;
  localparam logic [StW-1:0] S_STEP = 3'd5;
  localparam logic [StW-1:0] S_ENG  = 3'd6;
  localparam logic [StW-1:0] S_OUT  = 3'd7;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 20;
  localparam int unsigned MulBW = 18;
  localparam int unsigned MulPW = MulAW + MulBW;

  // energy scale and motor thresholds
  localparam logic [16:0] EnergyFull   = 17'd65536;
  localparam logic [16:0] EnergyOff    = 17'd3277;
  localparam logic [16:0] EnergyHeart  = 17'd19661;
  localparam logic [16:0] EnergyGallop = 17'd45876;

  localparam logic [11:0] HeartCycle   = 12'd1500;
  localparam logic [10:0] GallopCycle  = 11'd600;
  localparam logic [10:0] GallopCycle2 = 11'd1200;
  localparam logic [10:0] HuePeriod    = 11'd20;

  localparam logic [7:0] DutyHeart   = 8'd180;
  localparam logic [7:0] DutyGallop  = 8'd220;
  localparam logic [7:0] DutyShimmer = 8'd200;

  // quarter wave of 55*sin, 65 points
  localparam logic [5:0] QuarterSine [0:64] = '{
    6'd0,  6'd1,  6'd2,  6'd4,  6'd5,  6'd6,  6'd8,  6'd9,
    6'd10, 6'd12, 6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19,
    6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd27, 6'd28, 6'd29,
    6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37,
    6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd44,
    6'd45, 6'd46, 6'd47, 6'd47, 6'd48, 6'd49, 6'd49, 6'd50,
    6'd50, 6'd51, 6'd51, 6'd52, 6'd52, 6'd53, 6'd53, 6'd53,
    6'd53, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54, 6'd54,
    6'd55
  };

endpackage

FILE: design/motion_energy_haptic_driver.sv
// motion energy haptic driver: energy integrator, led bar, hue stepper and motor pattern
// the result is registered in OUT after GM, HI, LO, DEC, STEP and ENG
// a new tick is taken only after the 7-step sequence on the shared multiplier
// the input side is stalled while a tick is in work; a finished result waits in the
// output register and the next tick can start meanwhile
// reset (rst_ni low, async): control state zeroed, config to defaults, no clearing pass
module motion_energy_haptic_driver #(
  parameter int unsigned LEDS = 74
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   motion_mag_i,
  input  logic [9:0]                    dt_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [6:0]                    leds_lit_o,
  output logic [7:0]                    hue_base_o,
  output logic [7:0]                    motor_duty_o,
  output logic                          sleep_request_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mehd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mehd_pkg::CfgDataW-1:0] cfg_data_i
);
  import mehd_pkg::*;

  // bar length scale as a multiplier operand
  localparam logic [MulAW-1:0] LedsOp = MulAW'(LEDS);

  // configuration registers
  logic [19:0] charge_gain_q;
  logic [15:0] decay_per_ms_q;
  logic [15:0] motion_deadzone_q;
  logic [15:0] inact_timeout_q;
  logic [11:0] shimmer_step_q;

  // sequencer
  logic [StW-1:0] state_q, state_d;

  // captured tick and datapath payload
  logic [15:0] motion_q;
  logic [9:0]  dt_q;
  logic [35:0] gm_q;       // motion * gain
  logic [45:0] acc_q;      // motion * gain * dt
  logic [17:0] dec_q;      // decay * dt >> 8

  // architectural state
  logic [16:0] energy_q;
  logic [15:0] idle_ms_q;
  logic [10:0] heart_q;
  logic [9:0]  gallop_q;
  logic [15:0] shimmer_q;
  logic [4:0]  hue_timer_q;
  logic [7:0]  hue_value_q;
  logic [7:0]  hue_out_q;
  logic        sleep_q;

  // output register
  logic        out_valid_q;
  logic [6:0]  leds_q;
  logic [7:0]  hue_base_q;
  logic [7:0]  duty_q;
  logic        sleep_out_q;

  logic in_accept;
  logic out_free;

  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // shared multiplier: operands picked by the sequencer step
  // ---------------------------------------------------------------------------
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GM: begin
        mul_a = charge_gain_q;
        mul_b = {2'b0, motion_q};
      end
      S_HI: begin
        mul_a = {10'b0, dt_q};
        mul_b = gm_q[35:18];
      end
      S_LO: begin
        mul_a = {10'b0, dt_q};
        mul_b = gm_q[17:0];
      end
      S_DEC: begin
        mul_a = {10'b0, dt_q};
        mul_b = {2'b0, decay_per_ms_q};
      end
      S_STEP: begin
        mul_a = {10'b0, dt_q};
        mul_b = {6'b0, shimmer_step_q};
      end
      S_OUT: begin
        // bar length from the updated energy
        mul_a = LedsOp;
        mul_b = {1'b0, energy_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  // ---------------------------------------------------------------------------
  // per-tick counters: idle time, phases, hue
  // ---------------------------------------------------------------------------
  logic [16:0] idle_sum;
  logic [15:0] idle_d;
  logic [11:0] heart_sum;
  logic [10:0] heart_d;
  logic [10:0] gallop_sum;
  logic [9:0]  gallop_d;
  logic [10:0] hue_sum;

  always_comb begin
    idle_sum = {1'b0, idle_ms_q} + {7'b0, dt_q};
    if (motion_q > motion_deadzone_q) begin
      idle_d = '0;
    end else if (idle_sum[16]) begin
      idle_d = 16'hFFFF;                    // saturate
    end else begin
      idle_d = idle_sum[15:0];
    end

    heart_sum = {1'b0, heart_q} + {2'b0, dt_q};
    if (heart_sum >= HeartCycle) begin
      heart_d = 11'(heart_sum - HeartCycle);
    end else begin
      heart_d = heart_sum[10:0];
    end

    // sum stays below three gallop cycles
    gallop_sum = {1'b0, gallop_q} + {1'b0, dt_q};
    if (gallop_sum >= GallopCycle2) begin
      gallop_d = 10'(gallop_sum - GallopCycle2);
    end else if (gallop_sum >= GallopCycle) begin
      gallop_d = 10'(gallop_sum - GallopCycle);
    end else begin
      gallop_d = gallop_sum[9:0];
    end

    hue_sum = {6'b0, hue_timer_q} + {1'b0, dt_q};
  end

  // ---------------------------------------------------------------------------
  // energy update: charge minus decay, clamped to 0..full
  // ---------------------------------------------------------------------------
  logic signed [24:0] energy_sum;
  logic [16:0]        energy_d;

  always_comb begin
    energy_sum = $signed({8'b0, energy_q}) + $signed({3'b0, acc_q[45:24]})
               - $signed({7'b0, dec_q});
    if (energy_sum < 0) begin
      energy_d = '0;
    end else if (energy_sum > $signed({8'b0, EnergyFull})) begin
      energy_d = EnergyFull;
    end else begin
      energy_d = energy_sum[16:0];
    end
  end

  // ---------------------------------------------------------------------------
  // motor duty from energy band and phases
  // ---------------------------------------------------------------------------
  logic [7:0] shim_idx;
  logic [6:0] sine_j;
  logic [5:0] sine_mag;
  logic [7:0] duty_d;

  always_comb begin
    shim_idx = shimmer_q[15:8];
    // odd quadrants read the table mirrored
    if (shim_idx[6]) begin
      sine_j = 7'd64 - {1'b0, shim_idx[5:0]};
    end else begin
      sine_j = {1'b0, shim_idx[5:0]};
    end
    sine_mag = QuarterSine[sine_j];

    if (energy_q < EnergyOff) begin
      duty_d = '0;
    end else if (energy_q < EnergyHeart) begin
      duty_d = ((heart_q < 11'd100) || ((heart_q > 11'd300) && (heart_q < 11'd400)))
             ? DutyHeart : 8'd0;
    end else if (energy_q < EnergyGallop) begin
      duty_d = ((gallop_q < 10'd80) || ((gallop_q > 10'd160) && (gallop_q < 10'd240)))
             ? DutyGallop : 8'd0;
    end else if (shim_idx[7]) begin
      duty_d = DutyShimmer - {2'b0, sine_mag};     // negative half wave
    end else begin
      duty_d = DutyShimmer + {2'b0, sine_mag};
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: GM -> HI -> LO -> DEC -> STEP -> ENG -> OUT
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_accept) state_d = S_GM;
      S_GM:   state_d = S_HI;
      S_HI:   state_d = S_LO;
      S_LO:   state_d = S_DEC;
      S_DEC:  state_d = S_STEP;
      S_STEP: state_d = S_ENG;
      S_ENG:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;   // hold while the last result waits
      default: state_d = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      out_valid_q       <= 1'b0;
      charge_gain_q     <= ChargeGainRst;
      decay_per_ms_q    <= DecayPerMsRst;
      motion_deadzone_q <= DeadzoneRst;
      inact_timeout_q   <= InactTimeoutRst;
      shimmer_step_q    <= ShimmerStepRst;
      energy_q          <= '0;
      idle_ms_q         <= '0;
      heart_q           <= '0;
      gallop_q          <= '0;
      shimmer_q         <= '0;
      hue_timer_q       <= '0;
      hue_value_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CHARGE_GAIN:     charge_gain_q     <= cfg_data_i;
          CFG_DECAY_PER_MS:    decay_per_ms_q    <= cfg_data_i[15:0];
          CFG_MOTION_DEADZONE: motion_deadzone_q <= cfg_data_i[15:0];
          CFG_INACT_TIMEOUT:   inact_timeout_q   <= cfg_data_i[15:0];
          CFG_SHIMMER_STEP:    shimmer_step_q    <= cfg_data_i[11:0];
          default: ;
        endcase
      end

      if (state_q == S_GM) begin
        idle_ms_q <= idle_d;
        heart_q   <= heart_d;
        gallop_q  <= gallop_d;
        if (hue_sum >= HuePeriod) begin
          hue_value_q <= hue_value_q + 8'd1;
          hue_timer_q <= '0;
        end else begin
          hue_timer_q <= hue_sum[4:0];
        end
      end

      if (state_q == S_STEP) begin
        shimmer_q <= shimmer_q + mul_p[15:0];
      end

      if (state_q == S_ENG) begin
        energy_q <= energy_d;
      end

      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      motion_q <= motion_mag_i;
      dt_q     <= dt_ms_i;
    end
    case (state_q)
      S_GM: begin
        gm_q      <= mul_p[35:0];
        sleep_q   <= (idle_d > inact_timeout_q);
        hue_out_q <= hue_value_q;
      end
      S_HI:  acc_q <= {mul_p[27:0], 18'b0};
      S_LO:  acc_q <= acc_q + {18'b0, mul_p[27:0]};
      S_DEC: dec_q <= mul_p[25:8];
      default: ;
    endcase
    if ((state_q == S_OUT) && out_free) begin
      leds_q      <= mul_p[22:16];
      hue_base_q  <= hue_out_q;
      duty_q      <= duty_d;
      sleep_out_q <= sleep_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign leds_lit_o      = leds_q;
  assign hue_base_o      = hue_base_q;
  assign motor_duty_o    = duty_q;
  assign sleep_request_o = sleep_out_q;

`ifndef SYNTHESIS
  // an accepted tick always starts the multiply sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_GM))
    else $error("accepted tick did not start the sequence");

  // a new result only comes from the final sequencer step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result loaded outside the output step");

  // energy stays clamped to full scale
  a_energy_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    energy_q <= EnergyFull)
    else $error("energy above full scale");

  // pattern phases stay within their cycles
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heart_q < 11'd1500) && (gallop_q < 10'd600))
    else $error("motor phase out of range");
`endif

endmodule

FILE: dv/motion_energy_haptic_driver_tb.sv
// self-checking testbench for motion_energy_haptic_driver: directed tick table, then random ticks
// depends on mehd_pkg and the rtl top; a local predictor computes the expected result of every untyped tick
`timescale 1ns / 1ps

module motion_energy_haptic_driver_tb;
  import mehd_pkg::*;

  localparam int unsigned ClkPeriod  = 4;
  localparam int unsigned LedCount   = 74;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned SegItems   = 133;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned CfgIdxTop  = 2 ** CfgIdxW - 1;

  // one result transaction as the block presents it
  typedef struct packed {
    logic [6:0] leds;
    logic [7:0] hue;
    logic [7:0] duty;
    logic       sleep;
  } tick_result_t;

  // one row of the directed table; typed rows carry their result written out by hand
  typedef struct packed {
    logic [15:0]  motion;
    logic [9:0]   dt;
    logic         typed;
    tick_result_t want;
  } tick_row_t;

  typedef enum logic [1:0] {SET_TOP, SET_BOTTOM, SET_SCATTER, SET_DEFAULTS} reg_setting_e;
  typedef enum logic [1:0] {ACT_STILL, ACT_WALK, ACT_SHAKE} activity_e;

  // directed ticks, run with the reset register values
  localparam tick_row_t DirectedRows [0:23] = '{
    // right after reset, nothing moves
    '{16'h0000, 10'd0,    1'b1, '{7'd0,  8'd0, 8'd0,   1'b0}},
    // largest motion and largest dt: energy clamps at full
    '{16'hFFFF, 10'd1023, 1'b0, '0},
    // zero dt holds everything, hue shows the step from the previous tick
    '{16'h0000, 10'd0,    1'b1, '{7'd74, 8'd1, 8'd156, 1'b0}},
    // long quiet stretch: energy drains to zero, idle time passes the timeout
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    '{16'h0000, 10'd1023, 1'b0, '0},
    // motion equal to the deadzone keeps the idle count, one above clears it at zero dt
    '{16'h0300, 10'd0,    1'b0, '0},
    '{16'h0301, 10'd0,    1'b0, '0},
    // charge into the heartbeat band
    '{16'd20000, 10'd40,  1'b0, '0},
    // big motion with zero dt charges nothing
    '{16'hFFFF, 10'd0,    1'b0, '0},
    // hue timer around its period
    '{16'h0000, 10'd1,    1'b0, '0},
    '{16'h0000, 10'd19,   1'b0, '0},
    '{16'h0000, 10'd20,   1'b0, '0},
    '{16'd12000, 10'd100, 1'b0, '0},
    '{16'h5555, 10'd200,  1'b0, '0},
    '{16'hAAAA, 10'd300,  1'b0, '0}
  };

  localparam reg_setting_e SegmentSetting [0:5] = '{
    SET_TOP, SET_SCATTER, SET_BOTTOM, SET_SCATTER, SET_DEFAULTS, SET_SCATTER
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic [15:0] in_motion = '0;
  logic [9:0]  in_dt = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic       in_stall;
  logic       out_valid;
  logic [6:0] leds_lit;
  logic [7:0] hue_base;
  logic [7:0] motor_duty;
  logic       sleep_req;
  logic       cfg_ready;

  // register mirror, follows every accepted configuration transaction
  logic [19:0] cur_gain     = ChargeGainRst;
  logic [15:0] cur_decay    = DecayPerMsRst;
  logic [15:0] cur_deadzone = DeadzoneRst;
  logic [15:0] cur_timeout  = InactTimeoutRst;
  logic [11:0] cur_step     = ShimmerStepRst;

  // predicted block state, all zero after reset
  logic [16:0] pred_energy    = '0;
  logic [15:0] pred_idle_ms   = '0;
  logic [10:0] pred_heart     = '0;
  logic [9:0]  pred_gallop    = '0;
  logic [15:0] pred_shimmer   = '0;
  logic [4:0]  pred_hue_timer = '0;
  logic [7:0]  pred_hue       = '0;

  tick_result_t pending_results [$];
  int unsigned  mismatches = 0;
  int unsigned  send_gap_pct = 21;
  int unsigned  out_stall_pct = 71;
  int unsigned  big_dt_pct = 8;
  activity_e    activity = ACT_STILL;

  always #(ClkPeriod / 2) clk = ~clk;

  motion_energy_haptic_driver #(
    .LEDS(LedCount)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .motion_mag_i   (in_motion),
    .dt_ms_i        (in_dt),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .leds_lit_o     (leds_lit),
    .hue_base_o     (hue_base),
    .motor_duty_o   (motor_duty),
    .sleep_request_o(sleep_req),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // advance the predicted state by one tick and return the result it produces
  function automatic tick_result_t predict_tick(input logic [15:0] motion, input logic [9:0] dt);
    tick_result_t res;
    logic [16:0]  idle_sum;
    logic [63:0]  charge;
    logic [63:0]  leak;
    longint       level;
    logic [10:0]  hue_sum;
    logic [7:0]   sine_idx;
    logic [5:0]   sine_mag;
    // hue goes out as it was before this tick's step
    res.hue = pred_hue;
    // idle count: cleared by motion above the deadzone, otherwise saturating
    if (motion > cur_deadzone) begin
      pred_idle_ms = '0;
    end else begin
      idle_sum = {1'b0, pred_idle_ms} + 17'(dt);
      pred_idle_ms = idle_sum[16] ? 16'hFFFF : idle_sum[15:0];
    end
    res.sleep = (pred_idle_ms > cur_timeout);
    // energy: charge minus decay, wide, then clamped to 0..full
    charge = (64'(motion) * 64'(cur_gain) * 64'(dt)) >> 24;
    leak   = (64'(cur_decay) * 64'(dt)) >> 8;
    level  = longint'(pred_energy) + longint'(charge) - longint'(leak);
    if (level > longint'(EnergyFull)) level = longint'(EnergyFull);
    if (level < 0) level = 0;
    pred_energy = 17'(level);
    // pattern phases
    pred_heart   = 11'((32'(pred_heart) + 32'(dt)) % 32'(HeartCycle));
    pred_gallop  = 10'((32'(pred_gallop) + 32'(dt)) % 32'(GallopCycle));
    pred_shimmer = pred_shimmer + 16'(32'(cur_step) * 32'(dt));
    // hue stepper
    hue_sum = 11'(pred_hue_timer) + 11'(dt);
    if (hue_sum >= HuePeriod) begin
      pred_hue       = pred_hue + 8'd1;
      pred_hue_timer = '0;
    end else begin
      pred_hue_timer = hue_sum[4:0];
    end
    res.leds = 7'((64'(pred_energy) * 64'(LedCount)) >> 16);
    // motor pattern chosen by the updated energy
    if (pred_energy < EnergyOff) begin
      res.duty = '0;
    end else if (pred_energy < EnergyHeart) begin
      res.duty = (pred_heart < 100 || (pred_heart > 300 && pred_heart < 400)) ? DutyHeart : '0;
    end else if (pred_energy < EnergyGallop) begin
      res.duty = (pred_gallop < 80 || (pred_gallop > 160 && pred_gallop < 240)) ?
                 DutyGallop : '0;
    end else begin
      // quarter-wave lookup: rising in quadrants 0 and 2, mirrored in 1 and 3
      sine_idx = pred_shimmer[15:8];
      sine_mag = sine_idx[6] ? QuarterSine[7'd64 - {1'b0, sine_idx[5:0]}]
                             : QuarterSine[{1'b0, sine_idx[5:0]}];
      res.duty = sine_idx[7] ? DutyShimmer - 8'(sine_mag) : DutyShimmer + 8'(sine_mag);
    end
    return res;
  endfunction

  // offer one tick, wait for its transaction, then record what it should produce
  task automatic send_tick(input logic [15:0] motion, input logic [9:0] dt,
                           input logic typed, input tick_result_t want);
    tick_result_t model_out;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_motion <= motion;
    in_dt     <= dt;
    do @(posedge clk); while (in_stall);
    model_out = predict_tick(motion, dt);
    pending_results.push_back(typed ? want : model_out);
  endtask

  // valid stays high across back-to-back writes; the caller lowers it after the group
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CHARGE_GAIN:     cur_gain     = data[19:0];
      CFG_DECAY_PER_MS:    cur_decay    = data[15:0];
      CFG_MOTION_DEADZONE: cur_deadzone = data[15:0];
      CFG_INACT_TIMEOUT:   cur_timeout  = data[15:0];
      CFG_SHIMMER_STEP:    cur_step     = data[11:0];
      default: ;
    endcase
  endtask

  // program all five registers, plus one write to an unused index that must be ignored
  task automatic apply_setting(input reg_setting_e setting);
    logic [CfgDataW-1:0] gain;
    logic [CfgDataW-1:0] decay;
    logic [CfgDataW-1:0] deadzone;
    logic [CfgDataW-1:0] timeout;
    logic [CfgDataW-1:0] step;
    case (setting)
      SET_TOP: begin
        gain = 20'hFFFFF; decay = '0; deadzone = '0; timeout = '0; step = 20'h00FFF;
      end
      SET_BOTTOM: begin
        // deadzone at max never clears idle time, so the count saturates
        gain = '0; decay = 20'h0FFFF; deadzone = 20'h0FFFF; timeout = 20'h0FFFE; step = '0;
      end
      SET_DEFAULTS: begin
        // reset values but for the timeout, which goes to its maximum; junk above each narrower register's width
        gain     = ChargeGainRst;
        decay    = {4'hF, DecayPerMsRst};
        deadzone = {4'hA, DeadzoneRst};
        timeout  = {4'h5, 16'hFFFF};
        step     = {8'hC3, ShimmerStepRst};
      end
      default: begin
        gain     = 20'($urandom_range(100000, 900000));
        decay    = {4'($urandom()), 16'($urandom_range(2000, 30000))};
        deadzone = 20'($urandom_range(0, 2000));
        timeout  = 20'($urandom_range(0, 4000));
        step     = 20'($urandom());
      end
    endcase
    write_reg(CFG_CHARGE_GAIN, gain);
    write_reg(CFG_DECAY_PER_MS, decay);
    write_reg(CFG_MOTION_DEADZONE, deadzone);
    write_reg(CFG_INACT_TIMEOUT, timeout);
    write_reg(CFG_SHIMMER_STEP, step);
    write_reg(CfgIdxW'($urandom_range(int'(CFG_SHIMMER_STEP) + 1, CfgIdxTop)),
              CfgDataW'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // stop offering ticks and wait for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random tick: motion follows a slowly changing activity level, dt is mostly a
  // plausible tick interval with some zero, full-range and long-gap values mixed in
  task automatic send_random_tick();
    int unsigned pick;
    logic [15:0] motion;
    logic [9:0]  dt;
    if ($urandom_range(0, 11) == 0) activity = activity_e'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < big_dt_pct)            dt = 10'($urandom_range(512, 1023));
    else if (pick < big_dt_pct + 5)   dt = '0;
    else if (pick < big_dt_pct + 10)  dt = 10'($urandom());
    else                              dt = 10'($urandom_range(8, 80));
    if ($urandom_range(0, 9) == 0) begin
      motion = 16'($urandom());
    end else begin
      case (activity)
        ACT_STILL: motion = 16'($urandom_range(0, 1023));
        ACT_WALK:  motion = 16'($urandom_range(1024, 12000));
        default:   motion = 16'($urandom_range(12000, 65535));
      endcase
    end
    send_tick(motion, dt, 1'b0, '0);
  endtask

  // result side: random stall, every result transaction checked against the oldest expectation
  initial begin
    tick_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, got leds=%0d hue=%0d duty=%0d sleep=%0b",
                   $time, leds_lit, hue_base, motor_duty, sleep_req);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (want.leds != leds_lit) begin
            $display("%0t leds_lit: expected %0d, got %0d", $time, want.leds, leds_lit);
            mismatches++;
          end
          if (want.hue != hue_base) begin
            $display("%0t hue_base: expected %0d, got %0d", $time, want.hue, hue_base);
            mismatches++;
          end
          if (want.duty != motor_duty) begin
            $display("%0t motor_duty: expected %0d, got %0d", $time, want.duty, motor_duty);
            mismatches++;
          end
          if (want.sleep != sleep_req) begin
            $display("%0t sleep_request: expected %0b, got %0b", $time, want.sleep, sleep_req);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with the reset register values
    foreach (DirectedRows[i]) begin
      send_tick(DirectedRows[i].motion, DirectedRows[i].dt,
                DirectedRows[i].typed, DirectedRows[i].want);
    end
    wait_drained();

    // random segments, each under a fresh register setting; idling pattern per pair
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_gap_pct = 21; out_stall_pct = 71; end
        1: begin send_gap_pct = 71; out_stall_pct = 21; end
        default: begin send_gap_pct = 0; out_stall_pct = 0; end
      endcase
      // long gaps in the bottom setting push the idle count into saturation
      big_dt_pct = (SegmentSetting[3'(seg)] == SET_BOTTOM) ? 70 : 8;
      apply_setting(SegmentSetting[3'(seg)]);
      repeat (SegItems) send_random_tick();
      wait_drained();
    end

    // anything arriving late still gets checked
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
